@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/rcsbus_pkg.sv @@
// types, constants and helper functions of the sbus frame encoder
package rcsbus_pkg;

   localparam int FRAME_LEN = 25;
   localparam int NUM_CH    = 16;
   localparam int CH_BITS   = 11;

   localparam logic [7:0]  FRAME_SYNC        = 8'h0F;
   localparam logic [10:0] CH_LOW            = 11'd192;
   localparam logic [10:0] CH_HIGH           = 11'd1792;
   localparam logic [10:0] AUX_RESET         = 11'd172;
   localparam logic [18:0] CH14_Q16          = 19'd460555;
   localparam logic [12:0] PWM_FULL          = 13'd6666;
   localparam logic [15:0] RSSI_WEIGHT_RESET = 16'd655;

   typedef struct packed {
      logic [7:0] pkt_byte0;
      logic [7:0] pkt_byte1;
      logic [7:0] pkt_byte2;
      logic [7:0] pkt_byte3;
      logic [7:0] pkt_byte4;
      logic [7:0] pkt_switch_byte;
      logic [7:0] rssi_sample;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_last;
      logic [12:0] rssi_pwm_compare;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic avg;
      logic calc;
      logic shift;
   } dp_cmd_type;

   typedef struct packed {
      logic last_beat;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AVG,
      ST_CALC,
      ST_SEND
   } state_type;

   // floor(x / 1023) for x below 2^21, by folding the 1024-weighted part twice
   function automatic logic [10:0] div1023(input logic [20:0] x);
      logic [10:0] q0;
      logic [11:0] r0;
      logic [1:0]  q1;
      logic [10:0] r1;
      logic        q2;
      q0 = x[20:10];
      r0 = {2'b00, x[9:0]} + {1'b0, q0};
      q1 = r0[11:10];
      r1 = {1'b0, r0[9:0]} + {9'd0, q1};
      q2 = (r1 >= 11'd1023);
      return q0 + {9'd0, q1} + {10'd0, q2};
   endfunction

   // slot switch position to channel value, positions above six saturate
   function automatic logic [10:0] slot_map(input logic [2:0] pos);
      logic [10:0] val;
      case (pos)
         3'd0: val = 11'd192;
         3'd1: val = 11'd458;
         3'd2: val = 11'd725;
         3'd3: val = 11'd992;
         3'd4: val = 11'd1258;
         3'd5: val = 11'd1525;
         default: val = 11'd1792;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/rc_packet_to_sbus_frame_top.sv @@
// top level of the radio packet to sbus frame encoder
`include "assert_macros.svh"

// One accepted packet beat becomes a 25-beat sbus frame on the rsp channel, one byte per
// beat, with frame_last on the final byte and the rssi pwm compare value repeated on every
// beat. After a packet is taken the block passes through ST_AVG and ST_CALC for the rssi
// average and the channel math, then streams the frame from a single 200-bit shift register;
// req_stall stays high until the last frame byte is taken, and the next packet can be taken
// in the cycle after that, so the block takes no new packet while a frame is out. The rssi
// weight register may be written only while idle.
module rc_packet_to_sbus_frame_top #(
   parameter int SWITCH_SLOTS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rcsbus_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rcsbus_pkg::rsp_payload_type rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data
);
   import rcsbus_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rcsbus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcsbus_dp #(
      .SWITCH_SLOTS (SWITCH_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   logic sync_ok;
   logic last_take;

   assign sync_ok   = (rsp_payload.frame_byte == FRAME_SYNC);
   assign last_take = rsp_valid && !rsp_stall && rsp_payload.frame_last;

   // no new packet while a frame is out
   `ASSERT_SAME(a_no_accept_in_frame, clock, reset, rsp_valid, req_stall, "packet taken mid frame")
   // frame starts after the packet beat, once the ST_AVG and ST_CALC states have passed
   `ASSERT_SAME(a_frame_start, clock, reset, req_valid && !req_stall, ##3 rsp_valid, "frame late")
   // every frame opens with the sync byte
   `ASSERT_SAME(a_sync_first, clock, reset, $rose(rsp_valid), sync_ok, "bad sync byte")
   // frame ends after the last beat is taken
   `ASSERT_NEXT(a_frame_end, clock, reset, last_take, !rsp_valid, "beat after last")

endmodule

@@ rtl/rcsbus_ctrl.sv @@
// control state machine of the sbus frame encoder
module rcsbus_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rcsbus_pkg::dp_status_type status,
   output rcsbus_pkg::dp_cmd_type    cmd
);
   import rcsbus_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            cmd.avg  = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.shift = 1'b1;
               if (status.last_beat) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/rcsbus_dp.sv @@
// datapath: rssi average, channel math, aux slot store and frame shifter
module rcsbus_dp #(
   parameter int SWITCH_SLOTS = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [15:0]                csr_wr_data,
   input  rcsbus_pkg::req_payload_type req_payload,
   input  rcsbus_pkg::dp_cmd_type      cmd,
   output rcsbus_pkg::dp_status_type   status,
   output rcsbus_pkg::rsp_payload_type rsp_payload
);
   import rcsbus_pkg::*;

   localparam int FRAME_BITS = 8 * FRAME_LEN;
   localparam int CH_FIELD   = NUM_CH * CH_BITS;

   logic [39:0]           word_ff;
   logic [7:0]            sw_ff;
   logic [7:0]            sample_ff;
   logic [15:0]           weight_ff;
   logic [23:0]           avg_ff;
   logic [23:0]           avg_in;
   logic [20:0]           prod_ff [4];
   logic [FRAME_BITS-1:0] frame_ff;
   logic [12:0]           pwm_ff;
   logic [12:0]           pwm_in;
   logic [4:0]            beat_ff;
   logic [10:0]           aux_ff [SWITCH_SLOTS];

   // rssi average, old value weighted by 1 - w
   logic [16:0] keep_w;
   logic [40:0] old_part;
   logic [23:0] new_part;
   logic [41:0] avg_sum;

   assign keep_w   = 17'h10000 - {1'b0, weight_ff};
   assign old_part = {17'd0, avg_ff} * {24'd0, keep_w};
   assign new_part = {16'd0, sample_ff} * {8'd0, weight_ff};
   assign avg_sum  = {2'b00, new_part, 16'd0} + {1'b0, old_part};
   assign avg_in   = avg_sum[39:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= RSSI_WEIGHT_RESET;
         avg_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            weight_ff <= csr_wr_data;
         end
         if (cmd.avg) begin
            avg_ff <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff   <= {req_payload.pkt_byte4, req_payload.pkt_byte3, req_payload.pkt_byte2,
                       req_payload.pkt_byte1, req_payload.pkt_byte0};
         sw_ff     <= req_payload.pkt_switch_byte;
         sample_ff <= req_payload.rssi_sample;
      end
   end

   // stick times 1600 as shifts and adds
   always_ff @(posedge clock) begin
      if (cmd.avg) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= {1'b0, word_ff[10*i +: 10], 10'd0}
                        + {2'b00, word_ff[10*i +: 10], 9'd0}
                        + {5'd0, word_ff[10*i +: 10], 6'd0};
         end
      end
   end

   // channel 14 and pwm from the updated average, both rounded up
   logic [6:0]  half;
   logic [25:0] ch14_prod;
   logic [25:0] ch14_sum;
   logic [10:0] ch14_val;
   logic [28:0] pwm_prod;
   logic [28:0] pwm_sum;

   assign half      = avg_ff[23:17];
   assign ch14_prod = {19'd0, half} * {7'd0, CH14_Q16};
   assign ch14_sum  = ch14_prod + 26'd65535;
   assign ch14_val  = CH_HIGH - {1'b0, ch14_sum[25:16]};
   assign pwm_prod  = {5'd0, avg_ff} * 29'd26;
   assign pwm_sum   = pwm_prod + 29'd65535;
   assign pwm_in    = PWM_FULL - pwm_sum[28:16];

   // slot switch
   logic [3:0]  slot_k;
   logic [10:0] slot_val;
   logic [10:0] slot_hit;
   logic [10:0] aux_rd [9];

   assign slot_k   = sw_ff[4:1];
   assign slot_val = slot_map(sw_ff[7:5]);

   for (genvar i = 0; i < 11; i++) begin : g_hit
      if (i < SWITCH_SLOTS) begin : g_on
         assign slot_hit[i] = (slot_k == 4'(i));
      end else begin : g_off
         assign slot_hit[i] = 1'b0;
      end
   end

   for (genvar i = 0; i < 9; i++) begin : g_rd
      if (i < SWITCH_SLOTS) begin : g_on
         assign aux_rd[i] = aux_ff[i];
      end else begin : g_off
         assign aux_rd[i] = AUX_RESET;
      end
   end

   for (genvar i = 0; i < SWITCH_SLOTS; i++) begin : g_aux
      always_ff @(posedge clock) begin
         if (reset) begin
            aux_ff[i] <= AUX_RESET;
         end else if (cmd.calc && slot_hit[i]) begin
            aux_ff[i] <= slot_val;
         end
      end
   end

   // channel table and packing
   logic [10:0]         ch [NUM_CH];
   logic [CH_FIELD-1:0] ch_packed;

   always_comb begin
      ch[3] = div1023(prod_ff[0]) + CH_LOW;
      ch[2] = div1023(prod_ff[1]) + CH_LOW;
      ch[1] = div1023(prod_ff[2]) + CH_LOW;
      ch[0] = div1023(prod_ff[3]) + CH_LOW;
      ch[4] = sw_ff[0] ? CH_HIGH : CH_LOW;
      for (int i = 0; i < 9; i++) begin
         ch[5 + i] = aux_rd[i];
      end
      ch[14] = ch14_val;
      ch[15] = ch[2];
      for (int i = 0; i < 11; i++) begin
         if (slot_hit[i]) begin
            ch[5 + i] = slot_val;
         end
      end
      for (int c = 0; c < NUM_CH; c++) begin
         ch_packed[CH_BITS*c +: CH_BITS] = ch[c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         frame_ff <= {16'd0, ch_packed, FRAME_SYNC};
         pwm_ff   <= pwm_in;
      end else if (cmd.shift) begin
         frame_ff <= {8'd0, frame_ff[FRAME_BITS-1:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (cmd.calc) begin
         beat_ff <= '0;
      end else if (cmd.shift) begin
         beat_ff <= beat_ff + 5'd1;
      end
   end

   assign status.last_beat             = (beat_ff == 5'(FRAME_LEN - 1));
   assign rsp_payload.frame_byte       = frame_ff[7:0];
   assign rsp_payload.frame_last       = status.last_beat;
   assign rsp_payload.rssi_pwm_compare = pwm_ff;

endmodule

@@ dv/tb_rc_packet_to_sbus_frame_top.sv @@
// testbench for the radio packet to sbus frame encoder
module tb_rc_packet_to_sbus_frame_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcsbus_pkg::*;

   typedef longint unsigned u64_type;

   localparam int SLOT_COUNT  = 11;
   localparam int CYCLE_LIMIT = 600000;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en;
   logic [15:0]     csr_wr_data;

   // predictor state
   logic [10:0] aux_slots [SLOT_COUNT];
   logic [23:0] rssi_avg;
   logic [15:0] rssi_weight;

   rsp_payload_type pending_frame_bytes [$];

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b0;
   int unsigned holds_asked = 0;
   int unsigned holds_started = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_pick;

   rc_packet_to_sbus_frame_top #(
      .SWITCH_SLOTS(SLOT_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [10:0] scale_stick(input logic [9:0] v);
      return 11'(u64_type'(v) * 1600 / 1023 + 192);
   endfunction

   // works out the 25 bytes of the frame for one packet and updates the rssi and aux slot state
   function automatic void predict_frame(input req_payload_type p);
      logic [39:0]     sticks;
      logic [10:0]     ch [16];
      logic [175:0]    ch_bits;
      logic [3:0]      slot;
      logic [2:0]      pos;
      logic [10:0]     slot_val;
      u64_type         acc;
      logic [12:0]     pwm;
      rsp_payload_type beat;
      sticks = {p.pkt_byte4, p.pkt_byte3, p.pkt_byte2, p.pkt_byte1, p.pkt_byte0};
      ch[3] = scale_stick(sticks[9:0]);
      ch[2] = scale_stick(sticks[19:10]);
      ch[1] = scale_stick(sticks[29:20]);
      ch[0] = scale_stick(sticks[39:30]);
      ch[4] = p.pkt_switch_byte[0] ? CH_HIGH : CH_LOW;

      acc = ((u64_type'(p.rssi_sample) * u64_type'(rssi_weight)) << 16)
            + u64_type'(rssi_avg) * (u64_type'(65536) - u64_type'(rssi_weight));
      rssi_avg = 24'(acc >> 16);

      // integer part of the average, halved, times the q16 scale, rounded up
      ch[14] = CH_HIGH - 11'((u64_type'(rssi_avg[23:17]) * u64_type'(CH14_Q16) + 65535) >> 16);
      pwm = PWM_FULL - 13'((u64_type'(rssi_avg) * 26 + 65535) >> 16);

      for (int i = 0; i < 9; i++) ch[5 + i] = aux_slots[i];
      ch[15] = ch[2];

      slot = p.pkt_switch_byte[4:1];
      pos  = p.pkt_switch_byte[7:5];
      if (pos > 3'd6) pos = 3'd6;
      slot_val = 11'(u64_type'(pos) * 1600 / 6 + 192);
      if (slot < SLOT_COUNT) begin
         aux_slots[slot] = slot_val;
         ch[5 + slot] = slot_val;
      end

      for (int i = 0; i < 16; i++) ch_bits[11 * i +: 11] = ch[i];
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (i == 0) beat.frame_byte = FRAME_SYNC;
         else if (i <= 22) beat.frame_byte = ch_bits[8 * (i - 1) +: 8];
         else beat.frame_byte = 8'h00;
         beat.frame_last = (i == FRAME_LEN - 1);
         beat.rssi_pwm_compare = pwm;
         pending_frame_bytes.push_back(beat);
      end
   endfunction

   // packet monitor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) predict_frame(req_payload);
   end

   // frame byte checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frame_bytes.size() == 0) begin
            report_mismatch("frame beat with nothing pending");
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_payload.frame_byte !== want.frame_byte)
               report_mismatch($sformatf("frame_byte %h, want %h",
                  rsp_payload.frame_byte, want.frame_byte));
            if (rsp_payload.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %b, want %b",
                  rsp_payload.frame_last, want.frame_last));
            if (rsp_payload.rssi_pwm_compare !== want.rssi_pwm_compare)
               report_mismatch($sformatf("rssi_pwm_compare %0d, want %0d",
                  rsp_payload.rssi_pwm_compare, want.rssi_pwm_compare));
         end
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_started != holds_asked) begin
         holds_started++;
         hold_left = $urandom_range(150, 300);
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idling_on) begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 75) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 96) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(20, 60);
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called just after a rising edge; returns just after the edge that took the beat
   task automatic send_packet(input req_payload_type p);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one edge first so the monitor has queued the frame of the last packet beat
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rssi_weight(input logic [15:0] w);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rssi_weight = w;
   endtask

   function automatic req_payload_type make_packet(input logic [39:0] sticks,
                                                   input logic [7:0] sw,
                                                   input logic [7:0] sample);
      req_payload_type p;
      {p.pkt_byte4, p.pkt_byte3, p.pkt_byte2, p.pkt_byte1, p.pkt_byte0} = sticks;
      p.pkt_switch_byte = sw;
      p.rssi_sample     = sample;
      return p;
   endfunction

   function automatic req_payload_type random_packet();
      logic [7:0]  sample;
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) sample = 8'h00;
      else if (r == 1) sample = 8'hFF;
      else sample = 8'($urandom);
      return make_packet({8'($urandom), $urandom}, 8'($urandom), sample);
   endfunction

   task automatic test_stick_extremes();
      send_packet(make_packet(40'h00_0000_0000, 8'h00, 8'h00));
      send_packet(make_packet(40'hFF_FFFF_FFFF, 8'h01, 8'hFF));
      send_packet(make_packet(40'hAA_55AA_55AA, 8'h00, 8'h80));
      send_packet(make_packet(40'h55_AA55_AA55, 8'h01, 8'h7F));
      wait_idle();
   endtask

   // every slot index, in range and out of range, with all positions incl. saturation
   task automatic test_switch_slots();
      logic [3:0] k;
      for (int i = 0; i < 16; i++) begin
         k = 4'(i);
         send_packet(make_packet({5{8'(i * 17)}}, {3'(i), k, k[0]}, 8'(255 - i * 16)));
      end
      wait_idle();
   endtask

   task automatic test_rssi_weight();
      write_rssi_weight(16'hFFFF);
      send_packet(make_packet(40'h12_3456_789A, 8'h00, 8'hFF));
      send_packet(make_packet(40'h9A_7856_3412, 8'h01, 8'hFF));
      write_rssi_weight(16'h0000);
      send_packet(make_packet(40'h00_FFFF_0000, 8'h00, 8'h00));
      write_rssi_weight(RSSI_WEIGHT_RESET);
      send_packet(make_packet(40'hFF_0000_FFFF, 8'h01, 8'h40));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic [15:0] w;
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0: w = 16'($urandom_range(1, 4000));
            1: w = 16'h0000;
            2: w = 16'hFFFF;
            default: w = 16'($urandom);
         endcase
         write_rssi_weight(w);
         idling_on = (chunk != 1);
         repeat (22) send_packet(random_packet());
      end
      wait_idle();
   endtask

   // receiver holds off while packets keep coming, so the input has to stall
   task automatic test_backpressure();
      idling_on = 1'b0;
      write_rssi_weight(16'($urandom_range(1000, 30000)));
      holds_asked++;
      repeat (6) send_packet(random_packet());
      idling_on = 1'b1;
      repeat (4) send_packet(random_packet());
      wait_idle();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) aux_slots[i] = AUX_RESET;
      rssi_avg    = '0;
      rssi_weight = RSSI_WEIGHT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stick_extremes();
      test_switch_slots();
      test_rssi_weight();
      test_random_traffic();
      test_backpressure();

      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
